/* rtl/core/dh_kinematics_jacobian_top_defines.svh */
// Assertion macros for the kinematics block
`ifndef DH_KINEMATICS_JACOBIAN_TOP_DEFINES_SVH
`define DH_KINEMATICS_JACOBIAN_TOP_DEFINES_SVH

// antecedent implies consequent on the next edge
`define DHK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent on the same edge
`define DHK_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dhk_pkg.sv */
package dhk_pkg;
    localparam int CordicSteps = 30;
    localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic KindCol  = 1'b0;
    localparam logic KindPose = 1'b1;

    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            unique case (i)
                5'd0:  v = 34'sh20000000;
                5'd1:  v = 34'sh12E4051E;
                5'd2:  v = 34'sh09FB385B;
                5'd3:  v = 34'sh051111D4;
                5'd4:  v = 34'sh028B0D43;
                5'd5:  v = 34'sh0145D7E1;
                5'd6:  v = 34'sh00A2F61E;
                5'd7:  v = 34'sh00517C55;
                5'd8:  v = 34'sh0028BE53;
                5'd9:  v = 34'sh00145F2F;
                5'd10: v = 34'sh000A2F98;
                5'd11: v = 34'sh000517CC;
                5'd12: v = 34'sh00028BE6;
                5'd13: v = 34'sh000145F3;
                5'd14: v = 34'sh0000A2FA;
                5'd15: v = 34'sh0000517D;
                5'd16: v = 34'sh000028BE;
                5'd17: v = 34'sh0000145F;
                5'd18: v = 34'sh00000A30;
                5'd19: v = 34'sh00000518;
                5'd20: v = 34'sh0000028C;
                5'd21: v = 34'sh00000146;
                5'd22: v = 34'sh000000A3;
                5'd23: v = 34'sh00000051;
                5'd24: v = 34'sh00000029;
                5'd25: v = 34'sh00000014;
                5'd26: v = 34'sh0000000A;
                5'd27: v = 34'sh00000005;
                5'd28: v = 34'sh00000003;
                5'd29: v = 34'sh00000001;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        begin
            if (v > 36'sh07FFFFFFF)
                return 32'sh7FFFFFFF;
            else if (v < -36'sh080000000)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction
endpackage

/* rtl/core/dh_kinematics_jacobian_top.sv */
// The last joint adds the Jacobian columns and 3 pose rows.
// Per joint: two CORDIC passes on one shared rotator, then the 12-entry
// transform and 36 products of the chain on one shared 32x32 multiplier.
// A new joint is accepted only while idle; busy stays high while a joint is at work.
// Columns come first, pose rows back to back; the last one comes in the same cycle that busy goes low.
// Reset (rst_n, async low): idle, identity pose, joint count zero, standard DH.
module dh_kinematics_jacobian_top #(
    parameter int MAX_JOINTS = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic signed [15:0] joint_angle,
    input  logic signed [15:0] angle_offset,
    input  logic signed [15:0] twist_angle,
    input  logic signed [31:0] link_length,
    input  logic signed [31:0] link_offset,
    input  logic               last_joint,
    output logic               result_valid,
    output logic               result_kind,
    output logic [2:0]         result_index,
    output logic signed [31:0] elem0,
    output logic signed [31:0] elem1,
    output logic signed [31:0] elem2,
    output logic signed [31:0] elem3,
    output logic signed [31:0] elem4,
    output logic signed [31:0] elem5,
    output logic               last_result
);
    import dhk_pkg::*;
    `include "dh_kinematics_jacobian_top_defines.svh"

    localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CW = $clog2(MAX_JOINTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CORD  = 4'd1;
    localparam logic [3:0] S_CFIN  = 4'd2;
    localparam logic [3:0] S_TRAN  = 4'd3;
    localparam logic [3:0] S_SAVE  = 4'd4;
    localparam logic [3:0] S_CHAIN = 4'd5;
    localparam logic [3:0] S_JRD   = 4'd6;
    localparam logic [3:0] S_JDIF  = 4'd7;
    localparam logic [3:0] S_JMUL  = 4'd8;
    localparam logic [3:0] S_JOUT  = 4'd9;
    localparam logic [3:0] S_POSE  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       conv_reg;
    logic       conv_j_reg;
    logic       last_j_reg;
    logic [CW-1:0] jcnt_reg;

    logic [15:0] alpha_reg;
    logic signed [31:0] a_reg, d_reg;
    logic signed [31:0] ct_reg, st_reg, ca_reg, sa_reg;
    logic        cpass_reg;
    logic [4:0]  cstep_reg;
    logic        flip_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;

    logic signed [31:0] pose_reg [12];
    logic signed [31:0] tm_reg [12];
    logic signed [31:0] np_reg [12];
    logic signed [35:0] acc_reg;
    logic [5:0]  step_reg;
    // chain product position: row, column, term
    logic [1:0]  cr_reg, cc_reg, cm_reg;

    // frame store: origin xyz and z axis xyz per joint
    logic signed [31:0] org_mem [MAX_JOINTS][3];
    logic signed [31:0] zax_mem [MAX_JOINTS][3];
    logic signed [31:0] org_q [3];
    logic signed [31:0] zax_q [3];
    logic signed [31:0] p_reg [3];
    logic [JW-1:0] col_reg;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic signed [35:0] mul_r;

    assign busy = (state_reg != S_IDLE);
    wire accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            conv_reg <= 1'b0;
        else if (cfg_we)
            conv_reg <= cfg_wdata;
    end

    // shared multiplier with Q30 rounding
    assign mul_p = mul_a * mul_b;
    assign mul_r = 36'((mul_p + 64'sd536870912) >>> 30);

    // transform step: which entry and operands
    logic [3:0] t_idx;
    logic signed [31:0] t_val;
    logic [1:0] j_r, j_m;
    logic [1:0] j_c;
    logic [1:0] jx;
    always_comb
    begin
        t_idx = step_reg[3:0];
        j_r = cr_reg;
        j_c = cc_reg;
        j_m = cm_reg;
        jx = step_reg[1:0];
        mul_a = '0;
        mul_b = '0;
        t_val = '0;
        unique case (state_reg)
            S_TRAN:
            begin
                if (conv_j_reg)
                begin
                    unique case (t_idx)
                        4'd4:  begin mul_a = st_reg; mul_b = ca_reg; end
                        4'd5:  begin mul_a = ct_reg; mul_b = ca_reg; end
                        4'd7:  begin mul_a = d_reg;  mul_b = sa_reg; end
                        4'd8:  begin mul_a = st_reg; mul_b = sa_reg; end
                        4'd9:  begin mul_a = ct_reg; mul_b = sa_reg; end
                        4'd11: begin mul_a = d_reg;  mul_b = ca_reg; end
                        default: ;
                    endcase
                    unique case (t_idx)
                        4'd0:  t_val = ct_reg;
                        4'd1:  t_val = -st_reg;
                        4'd3:  t_val = a_reg;
                        4'd6:  t_val = -sa_reg;
                        4'd7:  t_val = sat32(-mul_r);
                        4'd10: t_val = ca_reg;
                        4'd4, 4'd5, 4'd8, 4'd9, 4'd11: t_val = sat32(mul_r);
                        default: t_val = '0;
                    endcase
                end
                else
                begin
                    unique case (t_idx)
                        4'd1:  begin mul_a = st_reg; mul_b = ca_reg; end
                        4'd2:  begin mul_a = st_reg; mul_b = sa_reg; end
                        4'd3:  begin mul_a = a_reg;  mul_b = ct_reg; end
                        4'd5:  begin mul_a = ct_reg; mul_b = ca_reg; end
                        4'd6:  begin mul_a = ct_reg; mul_b = sa_reg; end
                        4'd7:  begin mul_a = a_reg;  mul_b = st_reg; end
                        default: ;
                    endcase
                    unique case (t_idx)
                        4'd0:  t_val = ct_reg;
                        4'd4:  t_val = st_reg;
                        4'd9:  t_val = sa_reg;
                        4'd10: t_val = ca_reg;
                        4'd11: t_val = d_reg;
                        4'd1, 4'd6: t_val = sat32(-mul_r);
                        4'd2, 4'd3, 4'd5, 4'd7: t_val = sat32(mul_r);
                        default: t_val = '0;
                    endcase
                end
            end
            S_CHAIN:
            begin
                mul_a = pose_reg[4'(j_r) * 4 + 4'(j_m)];
                mul_b = tm_reg[4'(j_m) * 4 + 4'(j_c)];
            end
            S_JMUL:
            begin
                // six products: z1p2 z2p1 z2p0 z0p2 z0p1 z1p0
                unique case (step_reg[2:0])
                    3'd0: begin mul_a = zax_q[1]; mul_b = p_reg[2]; end
                    3'd1: begin mul_a = zax_q[2]; mul_b = p_reg[1]; end
                    3'd2: begin mul_a = zax_q[2]; mul_b = p_reg[0]; end
                    3'd3: begin mul_a = zax_q[0]; mul_b = p_reg[2]; end
                    3'd4: begin mul_a = zax_q[0]; mul_b = p_reg[1]; end
                    default: begin mul_a = zax_q[1]; mul_b = p_reg[0]; end
                endcase
            end
            default: ;
        endcase
    end

    // CORDIC rotator, one micro-rotation a cycle
    logic signed [33:0] cx_sh, cy_sh;
    assign cx_sh = cx_reg >>> cstep_reg;
    assign cy_sh = cy_reg >>> cstep_reg;

    logic signed [33:0] cx_cl, cy_cl;
    always_comb
    begin
        cx_cl = cx_reg;
        cy_cl = cy_reg;
        if (cx_reg > 34'(OneQ30)) cx_cl = 34'(OneQ30);
        if (cx_reg < -34'(OneQ30)) cx_cl = -34'(OneQ30);
        if (cy_reg > 34'(OneQ30)) cy_cl = 34'(OneQ30);
        if (cy_reg < -34'(OneQ30)) cy_cl = -34'(OneQ30);
        if (flip_reg)
        begin
            cx_cl = -cx_cl;
            cy_cl = -cy_cl;
        end
    end

    wire chain_end = last_j_reg || (32'(jcnt_reg) + 1 >= MAX_JOINTS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_CORD;
            S_CORD:  if (cstep_reg == 5'(CordicSteps - 1)) state_next = S_CFIN;
            S_CFIN:  state_next = cpass_reg ? S_TRAN : S_CORD;
            S_TRAN:  if (step_reg == 6'd11) state_next = S_SAVE;
            S_SAVE:  state_next = S_CHAIN;
            S_CHAIN:
                if (step_reg == 6'd35) state_next = chain_end ? S_JRD : S_IDLE;
            S_JRD:   state_next = S_JDIF;
            S_JDIF:  state_next = S_JMUL;
            S_JMUL:  if (step_reg == 6'd5) state_next = S_JOUT;
            S_JOUT:
                if (32'(col_reg) == 32'(jcnt_reg)) state_next = S_POSE;
                else state_next = S_JRD;
            S_POSE:  if (step_reg == 6'd2) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [35:0] cross_v;
    logic [3:0] np_idx;
    assign cross_v = acc_reg - mul_r;
    assign np_idx = 4'(j_r) * 4 + 4'(j_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            jcnt_reg     <= '0;
            result_valid <= 1'b0;
            last_result  <= 1'b0;
            for (int i = 0; i < 12; i++)
                pose_reg[i] <= (i == 0 || i == 5 || i == 10) ? OneQ30 : 32'sd0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= (state_reg == S_JOUT) || (state_reg == S_POSE);
            last_result  <= (state_reg == S_POSE) && (step_reg == 6'd2);
            unique case (state_reg)
                S_CHAIN:
                    if (step_reg == 6'd35)
                    begin
                        for (int i = 0; i < 12; i++)
                            pose_reg[i] <= (i == 11) ? sat32(acc_reg + mul_r) : np_reg[i];
                        if (!chain_end)
                            jcnt_reg <= jcnt_reg + 1'b1;
                    end
                S_POSE:
                begin
                    if (step_reg == 6'd2)
                    begin
                        jcnt_reg <= '0;
                        for (int i = 0; i < 12; i++)
                            pose_reg[i] <= (i == 0 || i == 5 || i == 10) ?
                                           OneQ30 : 32'sd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    alpha_reg  <= twist_angle;
                    a_reg      <= link_length;
                    d_reg      <= link_offset;
                    last_j_reg <= last_joint;
                    conv_j_reg <= conv_reg;
                    cpass_reg  <= 1'b0;
                    cstep_reg  <= '0;
                    cx_reg     <= CordicGain;
                    cy_reg     <= '0;
                    // reload from live inputs
                    begin
                        logic [15:0] th;
                        th = 16'(joint_angle + angle_offset);
                        flip_reg <= th[15] ^ th[14];
                        cz_reg <= 34'(signed'({th[15] ^ (th[15] ^ th[14]), th[14:0],
                                               16'h0000}));
                    end
                end
            S_CORD:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_lut(cstep_reg);
                end
                else
                begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_lut(cstep_reg);
                end
                cstep_reg <= cstep_reg + 1'b1;
            end
            S_CFIN:
            begin
                if (!cpass_reg)
                begin
                    ct_reg    <= cx_cl[31:0];
                    st_reg    <= cy_cl[31:0];
                    cpass_reg <= 1'b1;
                    cstep_reg <= '0;
                    cx_reg    <= CordicGain;
                    cy_reg    <= '0;
                    flip_reg  <= alpha_reg[15] ^ alpha_reg[14];
                    cz_reg    <= 34'(signed'({alpha_reg[15] ^ (alpha_reg[15] ^
                                  alpha_reg[14]), alpha_reg[14:0], 16'h0000}));
                end
                else
                begin
                    ca_reg   <= cx_cl[31:0];
                    sa_reg   <= cy_cl[31:0];
                    step_reg <= '0;
                end
            end
            S_TRAN:
            begin
                tm_reg[t_idx] <= t_val;
                step_reg <= (step_reg == 6'd11) ? 6'd0 : step_reg + 1'b1;
            end
            S_SAVE:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    org_mem[jcnt_reg[JW-1:0]][r] <= pose_reg[r * 4 + 3];
                    zax_mem[jcnt_reg[JW-1:0]][r] <= pose_reg[r * 4 + 2];
                end
                acc_reg  <= '0;
                step_reg <= '0;
                cr_reg   <= '0;
                cc_reg   <= '0;
                cm_reg   <= '0;
            end
            S_CHAIN:
            begin
                if (j_m == 2'd2)
                begin
                    np_reg[np_idx] <= sat32(acc_reg + mul_r);
                    // next entry starts with translation when it is column 3
                    if (j_c == 2'd2)
                        acc_reg <= 36'(pose_reg[np_idx + 4'd1]);
                    else
                        acc_reg <= '0;
                    cm_reg <= '0;
                    if (cc_reg == 2'd3)
                    begin
                        cc_reg <= '0;
                        cr_reg <= cr_reg + 1'b1;
                    end
                    else
                        cc_reg <= cc_reg + 1'b1;
                end
                else
                begin
                    acc_reg <= acc_reg + mul_r;
                    cm_reg  <= cm_reg + 1'b1;
                end
                step_reg <= (step_reg == 6'd35) ? 6'd0 : step_reg + 1'b1;
                col_reg  <= '0;
            end
            S_JRD:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    org_q[r] <= org_mem[col_reg][r];
                    zax_q[r] <= zax_mem[col_reg][r];
                end
            end
            S_JDIF:
            begin
                for (int r = 0; r < 3; r++)
                    p_reg[r] <= sat32(36'(pose_reg[r * 4 + 3]) - 36'(org_q[r]));
                step_reg <= '0;
            end
            S_JMUL:
            begin
                if (!step_reg[0])
                    acc_reg <= mul_r;
                else
                    unique case (step_reg[2:1])
                        2'd0: elem0 <= sat32(cross_v);
                        2'd1: elem1 <= sat32(cross_v);
                        default: elem2 <= sat32(cross_v);
                    endcase
                step_reg <= (step_reg == 6'd5) ? 6'd0 : step_reg + 1'b1;
            end
            S_JOUT:
            begin
                result_kind  <= KindCol;
                result_index <= 3'(col_reg);
                elem3 <= zax_q[0];
                elem4 <= zax_q[1];
                elem5 <= zax_q[2];
                col_reg <= col_reg + 1'b1;
            end
            S_POSE:
            begin
                result_kind  <= KindPose;
                result_index <= 3'(jx);
                elem0 <= pose_reg[jx * 4 + 0];
                elem1 <= pose_reg[jx * 4 + 1];
                elem2 <= pose_reg[jx * 4 + 2];
                elem3 <= pose_reg[jx * 4 + 3];
                elem4 <= '0;
                elem5 <= '0;
                step_reg <= step_reg + 1'b1;
            end
            default: ;
        endcase
    end

    `DHK_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "busy not set after accept")
    `DHK_ASSERT_NOW(a_last_pose, clk, rst_n, last_result, result_valid && result_kind,
                    "last result not a pose row")
    `DHK_ASSERT_NOW(a_out_busy, clk, rst_n, result_valid && !last_result, busy,
                    "result outside a run")
endmodule
